>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the sniffer core, the only RTL file that includes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, inactive while reset is high
`define TES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define TES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Types, signature constants and the signature compare function of the
// text encoding sniffer.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int HEADER_DEPTH = 11;
  localparam int HLEN_W       = 4;
  localparam int SPACE_W      = 10;
  localparam int SIG_W        = 8 * HEADER_DEPTH;

  localparam logic [SPACE_W-1:0] SPACE_MAX = '1;

  // Guess codes
  typedef enum logic [3:0] {
    GUESS_UTF8         = 4'd0,
    GUESS_UTF8_BOM     = 4'd1,
    GUESS_UTF16BE      = 4'd2,
    GUESS_UTF16LE      = 4'd3,
    GUESS_UTF32BE      = 4'd4,
    GUESS_UTF32LE      = 4'd5,
    GUESS_BINARY       = 4'd6,
    GUESS_UNKNOWN      = 4'd7,
    GUESS_UNDETERMINED = 4'd8
  } guess_t;

  typedef logic [7:0] hdr_t [HEADER_DEPTH];

  // Status of one UTF-16 byte order lane
  typedef struct packed {
    logic               valid;
    logic               in_pair;
    logic [SPACE_W-1:0] spaces;
  } u16_lane_t;

  // Signatures, left aligned, first byte in the top bits
  localparam logic [SIG_W-1:0] SIG_PS    = 88'h2521_5053_2D41_646F_6265_2D;
  localparam logic [SIG_W-1:0] SIG_PNG   = {64'h8950_4E47_0D0A_1A0A, 24'h0};
  localparam logic [SIG_W-1:0] SIG_GIF7  = {48'h4749_4638_3761, 40'h0};
  localparam logic [SIG_W-1:0] SIG_GIF9  = {48'h4749_4638_3961, 40'h0};
  localparam logic [SIG_W-1:0] SIG_JPG   = {24'hFFD8FF, 64'h0};
  localparam logic [SIG_W-1:0] SIG_PDF   = {40'h2550_4446_2D, 48'h0};
  localparam logic [SIG_W-1:0] SIG_U8BOM = {24'hEFBBBF, 64'h0};
  localparam logic [SIG_W-1:0] SIG_U16BE = {16'hFEFF, 72'h0};
  localparam logic [SIG_W-1:0] SIG_U16LE = {16'hFFFE, 72'h0};
  localparam logic [SIG_W-1:0] SIG_U32BE = {32'h0000_FEFF, 56'h0};

  localparam logic [HLEN_W-1:0] LEN_PS    = 4'd11;
  localparam logic [HLEN_W-1:0] LEN_PNG   = 4'd8;
  localparam logic [HLEN_W-1:0] LEN_GIF   = 4'd6;
  localparam logic [HLEN_W-1:0] LEN_JPG   = 4'd3;
  localparam logic [HLEN_W-1:0] LEN_PDF   = 4'd5;
  localparam logic [HLEN_W-1:0] LEN_U8BOM = 4'd3;
  localparam logic [HLEN_W-1:0] LEN_U16   = 4'd2;
  localparam logic [HLEN_W-1:0] LEN_U32   = 4'd4;

  // True when the stored header holds at least slen bytes and they match sig
  function automatic logic sig_match(input hdr_t hdr, input logic [HLEN_W-1:0] hlen,
                                     input logic [SIG_W-1:0] sig,
                                     input logic [HLEN_W-1:0] slen);
    logic hit;
    hit = (hlen >= slen);
    for (int i = 0; i < HEADER_DEPTH; i++) begin
      if ((HLEN_W'(i) < slen) && (hdr[i] != sig[SIG_W-1-8*i -: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

>>> rtl/tes_if.sv
// ----------------------------------------------------------------------------
// tes_in_if / tes_out_if
// Valid/ready channels of the sniffer: text bytes in, encoding guess out.
// ----------------------------------------------------------------------------
interface tes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, data_byte, has_byte, end_of_text, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_text, output ready);
endinterface

interface tes_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] guess;

  modport source (output valid, guess, input ready);
  modport sink   (input valid, guess, output ready);
endinterface

>>> rtl/tes_utf8.sv
// ----------------------------------------------------------------------------
// tes_utf8
// UTF-8 validity tracker: lead decode, continuation check, pending count.
// ----------------------------------------------------------------------------
module tes_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       clear,
  output logic       valid_next
);

  logic       valid;
  logic [1:0] pending;
  logic       seq_bad;
  logic [1:0] pending_next;
  logic       seq_bad_next;

  // Next state for one byte
  always_comb begin
    valid_next   = valid;
    pending_next = pending;
    seq_bad_next = seq_bad;
    if (take && valid) begin
      if (pending != 2'd0) begin
        seq_bad_next = seq_bad | (data_byte[7:6] != 2'b10);
        pending_next = pending - 2'd1;
        if ((pending_next == 2'd0) && seq_bad_next) begin
          valid_next = 1'b0;
        end
      end else begin
        seq_bad_next = 1'b0;
        if (data_byte == 8'h00) begin
          valid_next = 1'b0;
        end else if (!data_byte[7]) begin
          pending_next = 2'd0;
        end else if (data_byte[7:5] == 3'b110) begin
          pending_next = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          pending_next = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          pending_next = 2'd3;
        end else begin
          valid_next = 1'b0;
        end
      end
    end
  end

  // Hold state, drop it after each text
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= 1'b1;
      pending <= 2'd0;
      seq_bad <= 1'b0;
    end else begin
      valid   <= valid_next;
      pending <= pending_next;
      seq_bad <= seq_bad_next;
    end
  end

endmodule

>>> rtl/tes_u16_lane.sv
// ----------------------------------------------------------------------------
// tes_u16_lane
// One UTF-16 byte order: surrogate pairing check and saturating space count.
// ----------------------------------------------------------------------------
module tes_u16_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          hi,
  input  logic [7:0]          lo,
  input  logic                clear,
  output tes_pkg::u16_lane_t  lane_next
);

  tes_pkg::u16_lane_t lane;

  // Next state for one 16-bit unit
  always_comb begin
    lane_next = lane;
    if (take && lane.valid) begin
      if (!lane.in_pair) begin
        if (hi >= 8'hD8) begin
          if (hi[7:2] == 6'b110110) begin
            lane_next.in_pair = 1'b1;
          end else begin
            lane_next.valid = 1'b0;
          end
        end else if ((hi == 8'h00) && (lo == 8'h20)
                     && (lane.spaces != tes_pkg::SPACE_MAX)) begin
          lane_next.spaces = lane.spaces + 1'b1;
        end
      end else begin
        if (hi[7:2] != 6'b110111) begin
          lane_next.valid = 1'b0;
        end
        lane_next.in_pair = 1'b0;
      end
    end
  end

  // Hold state, drop it after each text
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      lane.valid   <= 1'b1;
      lane.in_pair <= 1'b0;
      lane.spaces  <= '0;
    end else begin
      lane <= lane_next;
    end
  end

endmodule

>>> rtl/tes_decide.sv
// ----------------------------------------------------------------------------
// tes_decide
// Priority decision: empty text, signatures, UTF-8, UTF-16, zero byte.
// ----------------------------------------------------------------------------
module tes_decide (
  input  tes_pkg::hdr_t                  hdr,
  input  logic [tes_pkg::HLEN_W-1:0]     hdr_len,
  input  logic                           utf8_valid,
  input  tes_pkg::u16_lane_t             be,
  input  tes_pkg::u16_lane_t             le,
  input  logic                           saw_zero,
  output tes_pkg::guess_t                guess
);

  logic be_ok;
  logic le_ok;

  assign be_ok = be.valid && (be.spaces != '0);
  assign le_ok = le.valid && (le.spaces != '0);

  // First check that decides wins
  always_comb begin
    if (hdr_len == '0) begin
      guess = tes_pkg::GUESS_UTF8;
    end else if (tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_PS, tes_pkg::LEN_PS)) begin
      guess = tes_pkg::GUESS_UNKNOWN;
    end else if (tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_PNG, tes_pkg::LEN_PNG)
              || tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_GIF7, tes_pkg::LEN_GIF)
              || tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_GIF9, tes_pkg::LEN_GIF)
              || tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_JPG, tes_pkg::LEN_JPG)
              || tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_PDF, tes_pkg::LEN_PDF)) begin
      guess = tes_pkg::GUESS_BINARY;
    end else if (tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_U8BOM,
                                     tes_pkg::LEN_U8BOM)) begin
      guess = tes_pkg::GUESS_UTF8_BOM;
    end else if (tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_U16BE, tes_pkg::LEN_U16)) begin
      guess = tes_pkg::GUESS_UTF16BE;
    end else if (tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_U16LE, tes_pkg::LEN_U16)) begin
      guess = tes_pkg::GUESS_UTF16LE;
    end else if (tes_pkg::sig_match(hdr, hdr_len, tes_pkg::SIG_U32BE, tes_pkg::LEN_U32)) begin
      guess = tes_pkg::GUESS_UTF32BE;
    end else if (utf8_valid) begin
      guess = tes_pkg::GUESS_UTF8;
    end else if (be_ok && le_ok) begin
      guess = (be.spaces > le.spaces) ? tes_pkg::GUESS_UTF16BE : tes_pkg::GUESS_UTF16LE;
    end else if (be_ok) begin
      guess = tes_pkg::GUESS_UTF16BE;
    end else if (le_ok) begin
      guess = tes_pkg::GUESS_UTF16LE;
    end else if (saw_zero) begin
      guess = tes_pkg::GUESS_BINARY;
    end else begin
      guess = tes_pkg::GUESS_UNDETERMINED;
    end
  end

endmodule

>>> rtl/text_encoding_sniffer_core.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer_core
// Guesses the encoding of a byte stream from signatures and UTF validity.
// ----------------------------------------------------------------------------
// Usage:
//   text (sink): one transaction per byte; has_byte marks a real byte and
//   end_of_text closes the text. Only the first SAMPLE_BYTES bytes are
//   examined; later bytes are dropped, but their end mark still counts.
//   result (source): one transaction per text carrying the guess code.
// Latency: the guess is valid on the cycle after the final transaction.
// Throughput: one byte per cycle while no guess waits on result.ready, set by
//   the single update pass from the per-text state registers to the result
//   register. Texts may follow each other with no gap.
// Reset: all per-text state and the result valid flag clear; the header
//   bytes need no reset. State also clears after each final transaction.
// Stall: while a guess waits on result.ready, text.ready stays low, so the
//   block holds one guess and takes nothing until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_encoding_sniffer_core #(
  parameter int SAMPLE_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  tes_in_if.sink     text,
  tes_out_if.source  result
);

  localparam int CNT_W = $clog2(SAMPLE_BYTES + 1);

  logic [CNT_W-1:0]           byte_count;
  logic [CNT_W-1:0]           byte_count_next;
  tes_pkg::hdr_t              header_store;
  tes_pkg::hdr_t              header_next;
  logic [tes_pkg::HLEN_W-1:0] hdr_len;
  logic [7:0]                 even_byte_hold;
  logic                       saw_zero_byte;
  logic                       saw_zero_next;
  logic                       in_acc;
  logic                       text_done;
  logic                       take;
  logic                       unit_take;
  logic                       utf8_valid_next;
  tes_pkg::u16_lane_t         be_next;
  tes_pkg::u16_lane_t         le_next;
  tes_pkg::guess_t            guess_next;
  logic                       out_valid;
  tes_pkg::guess_t            out_guess;

  // Handshake
  assign text.ready = !out_valid || result.ready;
  assign in_acc     = text.valid && text.ready;
  assign text_done  = in_acc && text.end_of_text;
  assign take       = in_acc && text.has_byte && (byte_count < CNT_W'(SAMPLE_BYTES));
  assign unit_take  = take && byte_count[0];

  // Count, header capture, zero byte flag
  always_comb begin
    byte_count_next = take ? byte_count + 1'b1 : byte_count;
    saw_zero_next   = saw_zero_byte | (take && (text.data_byte == 8'h00));
    for (int i = 0; i < tes_pkg::HEADER_DEPTH; i++) begin
      header_next[i] = (take && (byte_count == CNT_W'(i))) ? text.data_byte
                                                            : header_store[i];
    end
    if (byte_count_next >= CNT_W'(tes_pkg::HEADER_DEPTH)) begin
      hdr_len = tes_pkg::HLEN_W'(tes_pkg::HEADER_DEPTH);
    end else begin
      hdr_len = byte_count_next[tes_pkg::HLEN_W-1:0];
    end
  end

  // Per-text state; clear after the final transaction
  always_ff @(posedge clk) begin
    if (rst || text_done) begin
      byte_count    <= '0;
      saw_zero_byte <= 1'b0;
    end else begin
      byte_count    <= byte_count_next;
      saw_zero_byte <= saw_zero_next;
    end
  end

  // Header bytes and the first byte of each 16-bit unit
  always_ff @(posedge clk) begin
    header_store <= header_next;
    if (take && !byte_count[0]) begin
      even_byte_hold <= text.data_byte;
    end
  end

  tes_utf8 u_utf8 (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (text.data_byte),
    .clear      (text_done),
    .valid_next (utf8_valid_next)
  );

  tes_u16_lane u_be (
    .clk       (clk),
    .rst       (rst),
    .take      (unit_take),
    .hi        (even_byte_hold),
    .lo        (text.data_byte),
    .clear     (text_done),
    .lane_next (be_next)
  );

  tes_u16_lane u_le (
    .clk       (clk),
    .rst       (rst),
    .take      (unit_take),
    .hi        (text.data_byte),
    .lo        (even_byte_hold),
    .clear     (text_done),
    .lane_next (le_next)
  );

  tes_decide u_decide (
    .hdr        (header_next),
    .hdr_len    (hdr_len),
    .utf8_valid (utf8_valid_next),
    .be         (be_next),
    .le         (le_next),
    .saw_zero   (saw_zero_next),
    .guess      (guess_next)
  );

  // Result register: load on the final transaction, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (text_done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_done) begin
      out_guess <= guess_next;
    end
  end

  assign result.valid = out_valid;
  assign result.guess = out_guess;

  // Checks
  `TES_ASSERT(a_count_clears, text_done |=> (byte_count == '0), "count not cleared after text")
  `TES_ASSERT(a_count_bound, byte_count <= CNT_W'(SAMPLE_BYTES), "count beyond sample size")
  `TES_ASSERT(a_rise_after_end, $rose(out_valid) |-> $past(text_done), "guess without end")
  `TES_ASSERT(a_no_utf32le, out_valid |-> (out_guess != tes_pkg::GUESS_UTF32LE),
              "utf32le guess produced")
  `TES_ASSERT(a_pair_valid, (!be_next.in_pair || be_next.valid)
              && (!le_next.in_pair || le_next.valid), "open pair on invalid lane")
  `TES_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid after reset")

endmodule
